// ===== hw/rtl/kct_pkg.sv =====
// Shared types and constants for the key and count table.
`default_nettype none
package kct_pkg;

	// Field widths of one operation and one result
	localparam int unsigned OP_W     = 3;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned FIDX_W   = 6;
	localparam int unsigned USED_W   = 7;

	// Packed stream widths, padded to whole bytes
	localparam int unsigned IN_BITS  = OP_W + KEY_W + CNT_W + POS_W + 2 + CNT_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = 1 + STAT_W + KEY_W + CNT_W + FIDX_W + USED_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 3'd0,
		OP_SET  = 3'd1,
		OP_GET  = 3'd2,
		OP_READ = 3'd3,
		OP_DEL  = 3'd4,
		OP_FIND = 3'd5
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Per-cell update strobes
	typedef struct packed {
		logic wr;     // load wr_key / wr_count
		logic shift;  // take the upper neighbor's entry
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kct_cell.sv =====
// One table slot: key and count storage, key compare and shift-down path.
`default_nettype none
module kct_cell (
	input  wire logic                      clk,
	input  wire kct_pkg::cell_ctrl_t       ctrl,
	input  wire logic [kct_pkg::KEY_W-1:0] nb_key,
	input  wire logic [kct_pkg::CNT_W-1:0] nb_count,
	input  wire logic [kct_pkg::KEY_W-1:0] wr_key,
	input  wire logic [kct_pkg::CNT_W-1:0] wr_count,
	input  wire logic [kct_pkg::KEY_W-1:0] probe_key,
	input  wire logic                      in_use,
	output logic      [kct_pkg::KEY_W-1:0] key_q,
	output logic      [kct_pkg::CNT_W-1:0] count_q,
	output logic                           match
);
	import kct_pkg::*;

	// storage: shift has priority over a direct write
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= nb_key;
			count_q <= nb_count;
		end else if (ctrl.wr) begin
			key_q   <= wr_key;
			count_q <= wr_count;
		end
	end

	// only occupied slots take part in the search
	assign match = in_use && (key_q == probe_key);

endmodule
`default_nettype wire

// ===== hw/rtl/kct_chain.sv =====
// Row of table cells with neighbor links and the hit / pick reduction.
`default_nettype none
module kct_chain #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire kct_pkg::cell_ctrl_t              ctrl [TABLE_DEPTH],
	input  wire logic [kct_pkg::KEY_W-1:0]        wr_key,
	input  wire logic [kct_pkg::CNT_W-1:0]        wr_count,
	input  wire logic [kct_pkg::KEY_W-1:0]        probe_key,
	input  wire logic [kct_pkg::POS_W-1:0]        probe_pos,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] used,
	output logic                                  hit,
	output logic      [$clog2(TABLE_DEPTH)-1:0]   hit_idx,
	output logic      [kct_pkg::CNT_W-1:0]        hit_count,
	output logic      [kct_pkg::KEY_W-1:0]        pick_key,
	output logic      [kct_pkg::CNT_W-1:0]        pick_count
);
	import kct_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [KEY_W-1:0] key_c   [TABLE_DEPTH];
	logic [CNT_W-1:0] count_c [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match_c;

	// cells, each fed by its upper neighbor
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nb_key;
		logic [CNT_W-1:0] nb_count;
		if (i == TABLE_DEPTH - 1) begin : g_top
			assign nb_key   = '0;
			assign nb_count = '0;
		end else begin : g_mid
			assign nb_key   = key_c[i+1];
			assign nb_count = count_c[i+1];
		end
		kct_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[i]),
			.nb_key    (nb_key),
			.nb_count  (nb_count),
			.wr_key    (wr_key),
			.wr_count  (wr_count),
			.probe_key (probe_key),
			.in_use    (CW'(i) < used),
			.key_q     (key_c[i]),
			.count_q   (count_c[i]),
			.match     (match_c[i])
		);
	end

	// OR-reduce: keys are unique, at most one cell matches
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		hit_count  = '0;
		pick_key   = '0;
		pick_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit       = hit | match_c[i];
			hit_idx   = hit_idx | (match_c[i] ? IW'(i) : '0);
			hit_count = hit_count | (match_c[i] ? count_c[i] : '0);
			if (32'(i) == 32'(probe_pos)) begin
				pick_key   = pick_key | key_c[i];
				pick_count = pick_count | count_c[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/key_count_table_unit.sv =====
// Top level of the key and count table: lookup stage, update control, result register.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  operation: opcode, key, value, position, flags, zero_default
// m_*      out  m_tvalid/m_tready  result: ok, status, key_out, count_out, found_index, used
//
// The transfer cycle of an operation searches all cells at once and registers the hit and
// the picked entry; the update cycle then updates the cells and loads the result register.
// Delete shifts every later cell down by one in that same update cycle.
// A new operation is taken while the previous result still waits in the result register;
// the update waits as long as that register is full and not taken.
// Reset clears the fill count and the handshake state; cell contents are not cleared.
`default_nettype none
module key_count_table_unit #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// opcode[2:0], key[34:3], value[66:35], position[73:67], add_new[74],
	// remove_empty[75], zero_default[107:76], zero pad above
	input  wire logic [kct_pkg::IN_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// ok[0], status[2:1], key_out[34:3], count_out[66:35], found_index[72:67],
	// entries_used[79:73]
	output logic      [kct_pkg::OUT_W-1:0]   m_tdata
);
	import kct_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// input field unpacking
	logic [OP_W-1:0]  in_opcode;
	logic [KEY_W-1:0] in_key;
	logic [CNT_W-1:0] in_value;
	logic [POS_W-1:0] in_position;
	logic             in_add_new;
	logic             in_remove_empty;
	logic [CNT_W-1:0] in_zero_default;

	assign in_opcode       = s_tdata[2:0];
	assign in_key          = s_tdata[34:3];
	assign in_value        = s_tdata[66:35];
	assign in_position     = s_tdata[73:67];
	assign in_add_new      = s_tdata[74];
	assign in_remove_empty = s_tdata[75];
	assign in_zero_default = s_tdata[107:76];

	logic [CW-1:0] used_q;
	cell_ctrl_t    ctrl [TABLE_DEPTH];
	logic [KEY_W-1:0] wr_key;
	logic [CNT_W-1:0] wr_count;

	logic             lk_hit;
	logic [IW-1:0]    lk_hit_idx;
	logic [CNT_W-1:0] lk_hit_count;
	logic [KEY_W-1:0] lk_pick_key;
	logic [CNT_W-1:0] lk_pick_count;

	kct_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_chain (
		.clk        (clk),
		.ctrl       (ctrl),
		.wr_key     (wr_key),
		.wr_count   (wr_count),
		.probe_key  (in_key),
		.probe_pos  (in_position),
		.used       (used_q),
		.hit        (lk_hit),
		.hit_idx    (lk_hit_idx),
		.hit_count  (lk_hit_count),
		.pick_key   (lk_pick_key),
		.pick_count (lk_pick_count)
	);

	// lookup stage registers
	logic             busy_s1;
	logic [OP_W-1:0]  op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [CNT_W-1:0] value_s1;
	logic [POS_W-1:0] pos_s1;
	logic             add_new_s1;
	logic             remove_empty_s1;
	logic [CNT_W-1:0] zdef_s1;
	logic             hit_s1;
	logic [IW-1:0]    hit_idx_s1;
	logic [CNT_W-1:0] hit_count_s1;
	logic [KEY_W-1:0] pick_key_s1;
	logic [CNT_W-1:0] pick_count_s1;

	logic in_xfer;
	logic exec;

	assign s_tready = !busy_s1;
	assign in_xfer  = s_tvalid && s_tready;
	assign exec     = busy_s1 && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_xfer) begin
			busy_s1 <= 1'b1;
		end else if (exec) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1           <= in_opcode;
			key_s1          <= in_key;
			value_s1        <= in_value;
			pos_s1          <= in_position;
			add_new_s1      <= in_add_new;
			remove_empty_s1 <= in_remove_empty;
			zdef_s1         <= in_zero_default;
			hit_s1          <= lk_hit;
			hit_idx_s1      <= lk_hit_idx;
			hit_count_s1    <= lk_hit_count;
			pick_key_s1     <= lk_pick_key;
			pick_count_s1   <= lk_pick_count;
		end
	end

	// update decision
	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	logic             shift_en;
	logic [IW-1:0]    shift_idx;
	logic [CW-1:0]    used_nxt;
	logic             r_ok;
	status_t          r_status;
	logic [KEY_W-1:0] r_key;
	logic [CNT_W-1:0] r_count;
	logic [FIDX_W-1:0] r_fidx;
	logic [CNT_W-1:0] sum;
	logic             pos_ok;
	logic             full;

	assign sum    = hit_count_s1 + value_s1;
	assign pos_ok = 32'(pos_s1) < 32'(used_q);
	assign full   = used_q == CW'(TABLE_DEPTH);
	assign wr_key = key_s1;

	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = hit_idx_s1;
		wr_count  = value_s1;
		shift_en  = 1'b0;
		shift_idx = hit_idx_s1;
		used_nxt  = used_q;
		r_ok      = 1'b0;
		r_status  = ST_DONE;
		r_key     = '0;
		r_count   = '0;
		r_fidx    = '0;
		unique case (op_s1)
			OP_ADD: begin
				if (hit_s1) begin
					r_ok = 1'b1;
					if (remove_empty_s1 && sum == '0) begin
						shift_en = 1'b1;
						used_nxt = used_q - 1'b1;
					end else begin
						wr_en    = 1'b1;
						wr_count = sum;
					end
				end else if (!add_new_s1) begin
					r_ok     = 1'b1;
					r_status = ST_NOT_FOUND;
				end else if (!full) begin
					wr_en    = 1'b1;
					wr_idx   = IW'(used_q);
					used_nxt = used_q + 1'b1;
					r_ok     = 1'b1;
				end else begin
					r_status = ST_FULL;
				end
			end
			OP_SET: begin
				if (hit_s1) begin
					wr_en = 1'b1;
					r_ok  = 1'b1;
				end else if (!add_new_s1) begin
					r_status = ST_NOT_FOUND;
				end else if (!full) begin
					wr_en    = 1'b1;
					wr_idx   = IW'(used_q);
					used_nxt = used_q + 1'b1;
					r_ok     = 1'b1;
				end else begin
					r_status = ST_FULL;
				end
			end
			OP_GET: begin
				if (hit_s1) begin
					r_ok    = 1'b1;
					r_count = (hit_count_s1 != '0) ? hit_count_s1 : zdef_s1;
				end else begin
					r_status = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (pos_ok) begin
					r_ok    = 1'b1;
					r_key   = pick_key_s1;
					r_count = pick_count_s1;
				end else begin
					r_status = ST_RANGE;
				end
			end
			OP_DEL: begin
				if (pos_ok) begin
					shift_en  = 1'b1;
					shift_idx = IW'(pos_s1);
					used_nxt  = used_q - 1'b1;
					r_ok      = 1'b1;
				end else begin
					r_status = ST_RANGE;
				end
			end
			OP_FIND: begin
				if (hit_s1) begin
					r_ok   = 1'b1;
					r_fidx = FIDX_W'(hit_idx_s1);
				end else begin
					r_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	// per-cell strobes, gated by the update cycle
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ctrl
		assign ctrl[i].wr    = exec && wr_en && (wr_idx == IW'(i));
		assign ctrl[i].shift = exec && shift_en && (IW'(i) >= shift_idx);
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (exec) begin
			used_q <= used_nxt;
		end
	end

	// result register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			m_tdata_q <= OUT_W'({USED_W'(used_nxt), r_fidx, r_count, r_key, r_status, r_ok});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> busy_s1)
		else $error("lookup stage not loaded after transfer");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= TABLE_DEPTH)
		else $error("fill count above table depth");

	a_shift_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && shift_en) |=> used_q == $past(used_q) - 1'b1)
		else $error("delete did not lower fill count");

	a_append_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && !hit_s1 && wr_en) |=> used_q == $past(used_q) + 1'b1)
		else $error("append did not raise fill count");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !(wr_en && shift_en))
		else $error("write and shift in the same update");

endmodule
`default_nettype wire

// ===== tb/sv/kct_result_checker.sv =====
// Result checker for the key and count table: mirrors the table and compares every result.
`timescale 1ns / 1ps
module kct_result_checker #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic                      s_tready,
	input  wire logic [kct_pkg::IN_W-1:0]  s_tdata,
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [kct_pkg::OUT_W-1:0] m_tdata,
	output int                             failures,
	output int                             pending
);
	import kct_pkg::*;

	// One operation as it travels on the input channel
	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] value;
		logic [POS_W-1:0] position;
		logic             add_new;
		logic             remove_empty;
		logic [CNT_W-1:0] zero_default;
	} table_op_t;

	// One result as it travels on the output channel
	typedef struct packed {
		logic              ok;
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  key_out;
		logic [CNT_W-1:0]  count_out;
		logic [FIDX_W-1:0] found_index;
		logic [USED_W-1:0] used;
	} table_result_t;

	// Mirror of the table contents
	logic [KEY_W-1:0] entry_key [DEPTH];
	logic [CNT_W-1:0] entry_cnt [DEPTH];
	int unsigned      fill = 0;

	table_result_t results_due [$];
	int            fail_cnt = 0;

	// First index holding the key, -1 when absent
	function automatic int find_key(input logic [KEY_W-1:0] k);
		for (int i = 0; i < int'(fill); i++)
			if (entry_key[i] == k)
				return i;
		return -1;
	endfunction

	// Delete one entry, later entries move down
	task automatic drop_entry(input int idx);
		for (int i = idx; i + 1 < int'(fill); i++) begin
			entry_key[i] = entry_key[i + 1];
			entry_cnt[i] = entry_cnt[i + 1];
		end
		fill--;
	endtask

	// Append a pair; refused when the table is full
	function automatic bit append_entry(input logic [KEY_W-1:0] k, input logic [CNT_W-1:0] c);
		if (fill >= DEPTH)
			return 1'b0;
		entry_key[fill] = k;
		entry_cnt[fill] = c;
		fill++;
		return 1'b1;
	endfunction

	// Apply one operation to the mirror and work out its result
	task automatic apply_table_op(input table_op_t op, output table_result_t res);
		int hit;
		res = '0;
		hit = -1;
		case (op.opcode)
			OP_ADD: begin
				hit = find_key(op.key);
				if (hit >= 0) begin
					entry_cnt[hit] = entry_cnt[hit] + op.value;
					if (op.remove_empty && entry_cnt[hit] == '0)
						drop_entry(hit);
					res.ok = 1'b1;
				end else if (!op.add_new) begin
					res.ok = 1'b1;
					res.status = ST_NOT_FOUND;
				end else if (append_entry(op.key, op.value)) begin
					res.ok = 1'b1;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_SET: begin
				hit = find_key(op.key);
				if (hit >= 0) begin
					entry_cnt[hit] = op.value;
					res.ok = 1'b1;
				end else if (!op.add_new) begin
					res.status = ST_NOT_FOUND;
				end else if (append_entry(op.key, op.value)) begin
					res.ok = 1'b1;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_GET: begin
				hit = find_key(op.key);
				if (hit >= 0) begin
					res.count_out = (entry_cnt[hit] != '0) ? entry_cnt[hit] : op.zero_default;
					res.ok = 1'b1;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (op.position < fill) begin
					res.key_out   = entry_key[op.position];
					res.count_out = entry_cnt[op.position];
					res.ok = 1'b1;
				end else begin
					res.status = ST_RANGE;
				end
			end
			OP_DEL: begin
				if (op.position < fill) begin
					drop_entry(int'(op.position));
					res.ok = 1'b1;
				end else begin
					res.status = ST_RANGE;
				end
			end
			OP_FIND: begin
				hit = find_key(op.key);
				if (hit >= 0) begin
					res.found_index = hit[FIDX_W-1:0];
					res.ok = 1'b1;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		res.used = fill[USED_W-1:0];
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Watch both channels; results are compared before the new operation is predicted
	always @(posedge clk) begin
		table_op_t     op;
		table_result_t got;
		table_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.ok          = m_tdata[0];
				got.status      = m_tdata[2:1];
				got.key_out     = m_tdata[34:3];
				got.count_out   = m_tdata[66:35];
				got.found_index = m_tdata[72:67];
				got.used        = m_tdata[79:73];
				if (results_due.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				end else begin
					want = results_due.pop_front();
					check_field("ok", 32'(want.ok), 32'(got.ok));
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("key_out", want.key_out, got.key_out);
					check_field("count_out", want.count_out, got.count_out);
					check_field("found_index", 32'(want.found_index), 32'(got.found_index));
					check_field("entries_used", 32'(want.used), 32'(got.used));
				end
			end
			if (s_tvalid && s_tready) begin
				op.opcode       = s_tdata[2:0];
				op.key          = s_tdata[34:3];
				op.value        = s_tdata[66:35];
				op.position     = s_tdata[73:67];
				op.add_new      = s_tdata[74];
				op.remove_empty = s_tdata[75];
				op.zero_default = s_tdata[107:76];
				apply_table_op(op, want);
				results_due.push_back(want);
			end
		end
		failures <= fail_cnt;
		pending  <= results_due.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the key and count table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import kct_pkg::*;

	localparam int unsigned DEPTH      = 64;
	localparam int unsigned RANDOM_OPS = 550;
	localparam int unsigned KEY_POOL   = 96;

	// Opcodes the block does not use
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_t;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int               failures;
	int               pending;

	logic [KEY_W-1:0] key_pool [KEY_POOL];
	int unsigned      fresh_idx = 0;
	int unsigned      burst_left = 0;
	logic [4:0]       rx_phase = '0;
	rx_mode_t         rx_mode = RX_OPEN;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	key_count_table_unit #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	kct_result_checker #(
		.DEPTH(DEPTH)
	) result_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.failures (failures),
		.pending  (pending)
	);

	// Receiver backpressure: a new pattern each time the phase counter wraps
	always @(negedge clk) begin
		rx_phase <= rx_phase + 5'd1;
		if (rx_phase == '1)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= (rx_phase[1:0] == 2'd0);
			default:   m_tready <= (rx_phase >= 5'd26);
		endcase
	end

	// Present one operation and hold it until the transfer
	task automatic send_op(input logic [OP_W-1:0] opcode, input logic [KEY_W-1:0] key,
			input logic [CNT_W-1:0] value, input logic [POS_W-1:0] position,
			input logic add_new, input logic remove_empty,
			input logic [CNT_W-1:0] zero_default);
		logic [IN_W-1:0] word;
		word = '0;
		word[2:0]    = opcode;
		word[34:3]   = key;
		word[66:35]  = value;
		word[73:67]  = position;
		word[74]     = add_new;
		word[75]     = remove_empty;
		word[107:76] = zero_default;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	// Bursts of random length, random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
	endtask

	// Stop sending until every result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	// One random operation, weighted by traffic mode
	task automatic random_op(input traffic_mode_t mode, output logic [OP_W-1:0] opcode);
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] value;
		logic [POS_W-1:0] position;
		logic             add_new;
		logic             remove_empty;
		int               pick;

		pick = $urandom_range(0, 9);
		case (mode)
			MODE_GROW: begin
				opcode = (pick < 4) ? OP_ADD : (pick < 8) ? OP_SET : (pick == 8) ? OP_GET : OP_FIND;
				add_new = ($urandom_range(0, 9) != 0);
				remove_empty = ($urandom_range(0, 9) < 3);
			end
			MODE_SHRINK: begin
				opcode = (pick < 4) ? OP_DEL : (pick < 7) ? OP_ADD : (pick == 7) ? OP_GET
					: (pick == 8) ? OP_READ : OP_FIND;
				add_new = ($urandom_range(0, 9) < 2);
				remove_empty = ($urandom_range(0, 9) < 8);
			end
			default: begin
				opcode = 3'($urandom_range(0, 7));
				add_new = 1'($urandom_range(0, 1));
				remove_empty = 1'($urandom_range(0, 1));
			end
		endcase

		// Mostly pool keys so lookups hit; fresh pool keys push the table to full
		pick = $urandom_range(0, 99);
		if (mode == MODE_GROW && pick < 45) begin
			key = key_pool[fresh_idx];
			fresh_idx = (fresh_idx + 1) % KEY_POOL;
		end else if (pick < 85) begin
			key = key_pool[$urandom_range(0, KEY_POOL - 1)];
		end else begin
			key = $urandom;
		end

		// Small values make counts land on zero often
		pick = $urandom_range(0, 9);
		if (pick < 5)
			value = $urandom_range(0, 6) - 3;
		else if (pick < 7)
			value = $urandom;
		else if (pick == 7)
			value = 32'h8000_0000;
		else if (pick == 8)
			value = 32'h7FFF_FFFF;
		else
			value = '0;

		pick = $urandom_range(0, 9);
		if (pick < 4)
			position = 7'($urandom_range(0, 7));
		else if (pick < 7)
			position = 7'($urandom_range(0, 63));
		else
			position = 7'($urandom_range(0, 127));

		send_op(opcode, key, value, position, add_new, remove_empty, $urandom);
	endtask

	initial begin
		logic [OP_W-1:0] last_op;
		traffic_mode_t   mode;
		int unsigned     sent;
		int unsigned     seg_left;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, unused opcodes, wraparound, zero default, removal on zero
		send_op(OP_GET,  32'h0000_0000, 32'h0, 7'd0, 1'b0, 1'b0, 32'h1234_5678);
		send_op(OP_FIND, 32'hFFFF_FFFF, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_READ, 32'h0, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_DEL,  32'h0, 32'h0, 7'd127, 1'b0, 1'b0, 32'h0);
		send_op(OP_SPARE_6, '1, '1, '1, 1'b1, 1'b1, '1);
		send_op(OP_SPARE_7, '0, '0, '0, 1'b0, 1'b0, '0);
		send_op(OP_ADD,  32'h0000_0000, 32'd5, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_SET,  32'h0000_0000, 32'd5, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_ADD,  32'h0000_0000, 32'h7FFF_FFFF, 7'd0, 1'b1, 1'b0, 32'h0);
		send_op(OP_SET,  32'hFFFF_FFFF, 32'h8000_0000, 7'd0, 1'b1, 1'b0, 32'h0);
		send_op(OP_ADD,  32'h0000_0000, 32'd1, 7'd0, 1'b0, 1'b1, 32'h0);
		send_op(OP_ADD,  32'hFFFF_FFFF, 32'h8000_0000, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_GET,  32'hFFFF_FFFF, 32'h0, 7'd0, 1'b0, 1'b0, 32'h7FFF_FFFF);
		send_op(OP_GET,  32'h0000_0000, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_SET,  32'h5A5A_A5A5, 32'd3, 7'd0, 1'b1, 1'b0, 32'h0);
		send_op(OP_ADD,  32'h5A5A_A5A5, -32'sd3, 7'd0, 1'b0, 1'b1, 32'h0);
		send_op(OP_FIND, 32'hFFFF_FFFF, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_READ, 32'h0, 32'h0, 7'd1, 1'b0, 1'b0, 32'h0);
		send_op(OP_READ, 32'h0, 32'h0, 7'd2, 1'b0, 1'b0, 32'h0);
		send_op(OP_DEL,  32'h0, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_READ, 32'h0, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		send_op(OP_FIND, 32'h0000_0000, 32'h0, 7'd0, 1'b0, 1'b0, 32'h0);
		drain_results();

		// Random traffic in segments; the first one fills the table
		sent = 0;
		mode = MODE_GROW;
		seg_left = 120;
		while (sent < RANDOM_OPS) begin
			if (seg_left == 0) begin
				mode = traffic_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(30, 90);
			end
			if (sent == RANDOM_OPS / 2)
				drain_results();
			pace_sender();
			random_op(mode, last_op);
			seg_left--;
			if (last_op != OP_SPARE_6 && last_op != OP_SPARE_7)
				sent++;
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("key_count_table_unit regression: pass");
		else
			$display("key_count_table_unit regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("key_count_table_unit regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/kct_pkg.sv
hw/rtl/kct_cell.sv
hw/rtl/kct_chain.sv
hw/rtl/key_count_table_unit.sv
tb/sv/kct_result_checker.sv
tb/sv/tb_top.sv
